FILE: rtl/core/montgomery_multiplier_carry_save_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Montgomery multiplier
// Shared concurrent assertion forms, clocked on clk, held off during reset.
// ----------------------------------------------------------------------------
`ifndef MONTGOMERY_MULTIPLIER_CARRY_SAVE_MACROS_SVH
`define MONTGOMERY_MULTIPLIER_CARRY_SAVE_MACROS_SVH

// same-cycle implication
`define MMCS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MMCS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/mmcs_pkg.sv
// ----------------------------------------------------------------------------
// Montgomery multiplier package
// Datapath widths, reset value of the modulus and the word passed between cells.
// ----------------------------------------------------------------------------
package mmcs_pkg;

  localparam int WIDTH   = 32;
  localparam int FIELD_W = 31;
  // carry-save datapath width: wide enough for the scan width and the operands
  localparam int DW      = (WIDTH > FIELD_W) ? WIDTH : FIELD_W;
  // resolved value 2*carry + sum
  localparam int PW      = DW + 2;

  localparam logic [DW-1:0]      DP_MASK     = {DW{1'b1}} >> (DW - WIDTH);
  localparam logic [FIELD_W-1:0] MODULUS_RST = FIELD_W'(7);

  typedef struct packed {
    logic [FIELD_W-1:0] a_rest;
    logic [FIELD_W-1:0] b;
    logic [DW-1:0]      sum;
    logic [DW-1:0]      carry;
  } mmcs_word_t;

endpackage

FILE: rtl/core/mmcs_cell.sv
// ----------------------------------------------------------------------------
// Montgomery iteration cell
// One radix-2 step on the carry-save pair: add b on the scanned bit, add the
// modulus when odd, halve; registers the word and hands it to the next cell.
// ----------------------------------------------------------------------------
module mmcs_cell (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [mmcs_pkg::FIELD_W-1:0]        modulus,
  input  logic                                up_valid,
  output logic                                up_ready,
  input  mmcs_pkg::mmcs_word_t                up_word,
  output logic                                dn_valid,
  input  logic                                dn_ready,
  output mmcs_pkg::mmcs_word_t                dn_word
);

  logic                         valid_r, valid_nxt;
  mmcs_pkg::mmcs_word_t         word_r, word_nxt;

  logic [mmcs_pkg::DW-1:0] b_ext, m_ext;
  logic [mmcs_pkg::DW-1:0] cs, gen, prop, sum1, carry1;
  logic [mmcs_pkg::DW-1:0] addend, g, h, g2, s2, g3;

  assign b_ext = mmcs_pkg::DW'(up_word.b);
  assign m_ext = mmcs_pkg::DW'(modulus);

  always_comb begin
    // conditional add of b on the scanned bit of a
    cs   = (up_word.carry << 1) & mmcs_pkg::DP_MASK;
    gen  = up_word.sum & b_ext;
    prop = up_word.sum ^ b_ext;
    if (up_word.a_rest[0]) begin
      sum1   = cs ^ prop;
      carry1 = gen | (cs & prop);
    end else begin
      sum1   = up_word.sum;
      carry1 = up_word.carry;
    end
    // add the modulus when odd, then halve
    addend = sum1[0] ? m_ext : '0;
    g      = sum1 & addend;
    h      = ((sum1 ^ addend) & mmcs_pkg::DP_MASK) >> 1;
    g2     = h & g;
    s2     = h ^ g;
    g3     = carry1 & s2;

    word_nxt.a_rest = up_word.a_rest >> 1;
    word_nxt.b      = up_word.b;
    word_nxt.sum    = carry1 ^ s2;
    word_nxt.carry  = g2 | g3;
  end

  assign up_ready  = !valid_r || dn_ready;
  assign valid_nxt = up_ready ? up_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      word_r <= word_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_word  = word_r;

endmodule

FILE: rtl/core/mmcs_reduce.sv
// ----------------------------------------------------------------------------
// Montgomery result reduction
// Resolves 2*carry + sum, then subtracts the modulus once if not below it.
// Two registered stages; the second is the output register.
// ----------------------------------------------------------------------------
module mmcs_reduce (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [mmcs_pkg::FIELD_W-1:0]   modulus,
  input  logic                           up_valid,
  output logic                           up_ready,
  input  logic [mmcs_pkg::DW-1:0]        sum,
  input  logic [mmcs_pkg::DW-1:0]        carry,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [mmcs_pkg::FIELD_W-1:0]   product
);

  logic                          p_valid_r, p_valid_nxt;
  logic [mmcs_pkg::PW-1:0]       p_r, p_nxt;
  logic                          p_ready;
  logic                          out_valid_r, out_valid_nxt;
  logic [mmcs_pkg::FIELD_W-1:0]  product_r, product_nxt;
  logic [mmcs_pkg::PW:0]         diff;
  logic [mmcs_pkg::PW-1:0]       reduced;

  assign p_nxt = mmcs_pkg::PW'({carry, 1'b0}) + mmcs_pkg::PW'(sum);

  // borrow out of the subtract means p is below the modulus
  assign diff        = {1'b0, p_r} - (mmcs_pkg::PW + 1)'(modulus);
  assign reduced     = diff[mmcs_pkg::PW] ? p_r : diff[mmcs_pkg::PW-1:0];
  assign product_nxt = reduced[mmcs_pkg::FIELD_W-1:0];

  assign p_ready       = !out_valid_r || out_ready;
  assign up_ready      = !p_valid_r || p_ready;
  assign p_valid_nxt   = up_ready ? up_valid : p_valid_r;
  assign out_valid_nxt = p_ready ? p_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      p_valid_r   <= p_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      p_r <= p_nxt;
    end
    if (p_valid_r && p_ready) begin
      product_r <= product_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign product   = product_r;

endmodule

FILE: rtl/core/montgomery_multiplier_carry_save.sv
// ----------------------------------------------------------------------------
// Montgomery multiplier, radix 2, carry-save chain of WIDTH cells
// Path: an accepted word passes the register of each of the WIDTH cells, then p_r and product_r in mmcs_reduce.
// Throughput: one word per cycle; a word enters every cycle while out_ready holds.
// Reset: synchronous active-low rst_n empties the chain; modulus resets to 7.
// ----------------------------------------------------------------------------
`include "montgomery_multiplier_carry_save_macros.svh"

module montgomery_multiplier_carry_save (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [mmcs_pkg::FIELD_W-1:0]  cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [mmcs_pkg::FIELD_W-1:0]  in_multiplicand,
  input  logic [mmcs_pkg::FIELD_W-1:0]  in_multiplier,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mmcs_pkg::FIELD_W-1:0]  out_product
);

  logic [mmcs_pkg::FIELD_W-1:0] modulus_r, modulus_nxt;

  logic [mmcs_pkg::WIDTH:0]     chain_valid;
  logic [mmcs_pkg::WIDTH:0]     chain_ready;
  mmcs_pkg::mmcs_word_t         chain_word [0:mmcs_pkg::WIDTH];

  assign modulus_nxt = cfg_wr_en ? cfg_wr_data : modulus_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= mmcs_pkg::MODULUS_RST;
    end else begin
      modulus_r <= modulus_nxt;
    end
  end

  assign chain_valid[0]       = in_valid;
  assign in_ready             = chain_ready[0];
  assign chain_word[0].a_rest = in_multiplicand;
  assign chain_word[0].b      = in_multiplier;
  assign chain_word[0].sum    = '0;
  assign chain_word[0].carry  = '0;

  genvar i;
  generate
    for (i = 0; i < mmcs_pkg::WIDTH; i++) begin : g_cell
      mmcs_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .modulus  (modulus_r),
        .up_valid (chain_valid[i]),
        .up_ready (chain_ready[i]),
        .up_word  (chain_word[i]),
        .dn_valid (chain_valid[i+1]),
        .dn_ready (chain_ready[i+1]),
        .dn_word  (chain_word[i+1])
      );
    end
  endgenerate

  mmcs_reduce u_reduce (
    .clk       (clk),
    .rst_n     (rst_n),
    .modulus   (modulus_r),
    .up_valid  (chain_valid[mmcs_pkg::WIDTH]),
    .up_ready  (chain_ready[mmcs_pkg::WIDTH]),
    .sum       (chain_word[mmcs_pkg::WIDTH].sum),
    .carry     (chain_word[mmcs_pkg::WIDTH].carry),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .product   (out_product)
  );

  // an open output lets the whole chain advance
  `MMCS_ASSERT_SAME(a_ready_chain, out_ready, in_ready, "chain blocked with out_ready high")
  `MMCS_ASSERT_NEXT(a_first_load, in_valid && in_ready, chain_valid[1], "accepted word not in first cell")
  `MMCS_ASSERT_NEXT(a_tail_hold, chain_valid[mmcs_pkg::WIDTH] && !chain_ready[mmcs_pkg::WIDTH], chain_valid[mmcs_pkg::WIDTH] && $stable(chain_word[mmcs_pkg::WIDTH]), "stalled tail word changed")

endmodule

FILE: tb/montgomery_multiplier_carry_save_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Montgomery multiplier testbench
// Streams operand pairs through the carry-save multiplier under several moduli,
// predicts each product with a bit-level model of the carry-save iterations,
// and checks every product in order while both sides idle and stall at random.
// ----------------------------------------------------------------------------
module montgomery_multiplier_carry_save_tb;

  localparam int FW           = mmcs_pkg::FIELD_W;
  localparam int PIPE_LATENCY = mmcs_pkg::WIDTH + 2;
  localparam logic [FW-1:0] MAX_MOD  = {FW{1'b1}};
  localparam logic [FW-1:0] EVEN_MOD = 31'h4000_0000;
  localparam int HOLD_CYCLES  = 300;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          cfg_wr_en = 1'b0;
  logic [FW-1:0] cfg_wr_data = '0;
  logic          in_valid = 1'b0;
  logic          in_ready;
  logic [FW-1:0] in_multiplicand = '0;
  logic [FW-1:0] in_multiplier = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  logic [FW-1:0] out_product;

  logic [FW-1:0] modulus_reg;
  logic [FW-1:0] expected_products[$];
  logic          idle_on = 1'b1;
  logic          hold_off = 1'b0;
  int            rx_gap;
  int            mismatch_count;
  int            products_checked;
  int            words_sent;
  int            modulus_writes;

  montgomery_multiplier_carry_save DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_multiplicand (in_multiplicand),
    .in_multiplier   (in_multiplier),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_product     (out_product)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("timeout with %0d products still pending", expected_products.size());
    $display("status: fail");
    $finish;
  end

  // W radix-2 steps on a carry-save pair, then resolve and reduce once
  function automatic logic [FW-1:0] montgomery_product(input logic [FW-1:0] a,
                                                       input logic [FW-1:0] b,
                                                       input logic [FW-1:0] m);
    logic [63:0] mask, a_w, b_w, m_w, sum, carry, shifted, gen, prop;
    logic [63:0] addend, g, h, g2, s2, t, c_next, resolved;
    mask  = (64'd1 << mmcs_pkg::WIDTH) - 64'd1;
    a_w   = 64'(a);
    b_w   = 64'(b);
    m_w   = 64'(m);
    sum   = '0;
    carry = '0;
    for (int i = 0; i < mmcs_pkg::WIDTH; i++) begin
      if (((a_w >> i) & 64'd1) != 64'd0) begin
        shifted = (carry << 1) & mask;
        gen     = sum & b_w;
        prop    = sum ^ b_w;
        sum     = shifted ^ prop;
        carry   = gen | (shifted & prop);
      end
      addend = sum[0] ? m_w : 64'd0;
      g      = sum & addend;
      h      = ((sum ^ addend) & mask) >> 1;
      g2     = h & g;
      s2     = h ^ g;
      t      = carry ^ s2;
      c_next = g2 | (carry & s2);
      sum    = t;
      carry  = c_next;
    end
    resolved = 2 * carry + sum;
    if (resolved >= m_w) begin
      resolved = resolved - m_w;
    end
    return resolved[FW-1:0];
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99, 0);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(2, 1);
    if (r < 96) return $urandom_range(10, 3);
    return $urandom_range(60, 20);
  endfunction

  function automatic logic [FW-1:0] rand_operand(input logic [FW-1:0] m);
    int r;
    r = $urandom_range(99, 0);
    if (r < 8 || m == '0) return FW'($urandom);
    if (r < 14) return m - 1'b1;
    if (r < 18) return '0;
    return FW'($urandom_range(32'(m) - 1, 0));
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch: %s", what);
    mismatch_count++;
  endtask

  task automatic check_product(input logic [FW-1:0] actual);
    logic [FW-1:0] wanted;
    if (expected_products.size() == 0) begin
      report_mismatch($sformatf("product %0h with none pending", actual));
    end else begin
      wanted = expected_products.pop_front();
      if (actual !== wanted) begin
        report_mismatch($sformatf("product %0h, want %0h", actual, wanted));
      end
      products_checked++;
    end
  endtask

  // receive side: check at the edge, then pick out_ready for the next cycle
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      check_product(out_product);
    end
    if (hold_off) begin
      out_ready <= 1'b0;
    end else if (rx_gap > 0) begin
      out_ready <= 1'b0;
      rx_gap = rx_gap - 1;
    end else if (idle_on && $urandom_range(3, 0) == 0) begin
      out_ready <= 1'b0;
      rx_gap = pick_gap();
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_word(input logic [FW-1:0] a, input logic [FW-1:0] b);
    in_valid        <= 1'b1;
    in_multiplicand <= a;
    in_multiplier   <= b;
    do @(posedge clk); while (!in_ready);
    expected_products.push_back(montgomery_product(a, b, modulus_reg));
    words_sent++;
  endtask

  task automatic offer_word(input logic [FW-1:0] a, input logic [FW-1:0] b);
    int gap;
    gap = idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    send_word(a, b);
  endtask

  // nothing pending means the input is already idle
  task automatic wait_for_results();
    if (expected_products.size() != 0) begin
      in_valid <= 1'b0;
      while (expected_products.size() != 0) @(posedge clk);
    end
  endtask

  task automatic write_modulus(input logic [FW-1:0] m);
    wait_for_results();
    repeat (PIPE_LATENCY + 4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    modulus_reg = m;
    modulus_writes++;
  endtask

  task automatic test_reset_modulus();
    offer_word('0, '0);
    offer_word(31'd6, 31'd6);
    offer_word(31'd1, 31'd6);
    offer_word(31'd3, 31'd5);
  endtask

  task automatic test_full_modulus_extremes();
    write_modulus(MAX_MOD);
    offer_word('0, MAX_MOD - 1'b1);
    offer_word(MAX_MOD - 1'b1, MAX_MOD - 1'b1);
    offer_word(31'd1, 31'd1);
    offer_word(MAX_MOD - 1'b1, 31'd1);
    // operands equal to the modulus: not reduced on the way in
    offer_word(MAX_MOD, MAX_MOD);
    offer_word(31'h5555_5555, 31'h2AAA_AAAA);
    offer_word(31'h2AAA_AAAA, 31'h5555_5555);
  endtask

  task automatic test_degenerate_moduli();
    write_modulus(31'd1);
    offer_word('0, '0);
    offer_word(31'd5, 31'd9);
    write_modulus(EVEN_MOD);
    offer_word(31'h3FFF_FFFF, 31'h1234_5678);
    offer_word(31'd7, 31'd3);
    write_modulus('0);
    offer_word(MAX_MOD, MAX_MOD);
    offer_word(31'd3, 31'd3);
  endtask

  task automatic test_random_stream();
    logic [FW-1:0] m;
    int count;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: m = 31'd3;
        1: m = MAX_MOD;
        2: m = FW'($urandom) | 31'd1;
        3: m = FW'($urandom_range(4095, 5)) | 31'd1;
        4: m = FW'($urandom) | 31'h4000_0001;
        5: m = FW'($urandom) & ~31'd1;
        6: m = FW'($urandom) | 31'd1;
        default: m = FW'($urandom_range(65535, 3)) | 31'd1;
      endcase
      write_modulus(m);
      // one phase runs flat out on both sides
      idle_on <= (phase != 2);
      count = (phase == 5) ? 40 : 120;
      for (int n = 0; n < count; n++) begin
        if ($urandom_range(199, 0) == 0) begin
          wait_for_results();
        end
        offer_word(rand_operand(m), rand_operand(m));
      end
    end
    idle_on <= 1'b1;
  endtask

  task automatic test_backpressure();
    write_modulus(FW'($urandom) | 31'd1);
    idle_on <= 1'b0;
    // stall the result side long enough for the chain to fill and push back
    fork
      begin
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
      end
    join_none
    for (int n = 0; n < 64; n++) begin
      send_word(rand_operand(modulus_reg), rand_operand(modulus_reg));
    end
    wait_for_results();
    idle_on <= 1'b1;
  endtask

  initial begin
    modulus_reg      = mmcs_pkg::MODULUS_RST;
    rx_gap           = 0;
    mismatch_count   = 0;
    products_checked = 0;
    words_sent       = 0;
    modulus_writes   = 0;
    rst_n <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_modulus();
    test_full_modulus_extremes();
    test_degenerate_moduli();
    test_random_stream();
    test_backpressure();

    wait_for_results();
    repeat (PIPE_LATENCY + 8) @(posedge clk);
    $display("run covered %0d words under %0d modulus writes, %0d products checked",
             words_sent, modulus_writes, products_checked);
    $display("incl. reset, unit, zero, even and full-width moduli and a long output stall");
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
